### rtl/core/lef_pkg.sv
// Package for the 3x3 Laplacian edge filter: constants, payload structs,
// the window type and configuration register indexes. No dependencies.
package lef_pkg;

    localparam int PIX_W      = 8;
    localparam int COL_W      = 10;
    localparam int ROW_W      = 12;
    localparam int FW_W       = 11;
    localparam int FH_W       = 12;
    localparam int CFG_DATA_W = 12;
    localparam int MAX_WIDTH  = 1024;
    localparam int LINE_ADDR_W = COL_W;
    localparam int MIN_DIM    = 3;
    localparam int WIN_TAPS   = 9;
    localparam int TAP_CENTRE = 4;
    localparam int FW_RESET   = 640;
    localparam int FH_RESET   = 480;

    // Configuration register indexes
    localparam logic CFG_FRAME_WIDTH  = 1'b0;
    localparam logic CFG_FRAME_HEIGHT = 1'b1;

    typedef struct packed {
        logic [PIX_W-1:0] pixel_in;
        logic             frame_start;
    } t_pix_in;

    typedef struct packed {
        logic [PIX_W-1:0] pixel_out;
        logic [ROW_W-1:0] out_row;
        logic [COL_W-1:0] out_col;
        logic             filtered;
    } t_pix_out;

    // Taps 0..8 in row-major order: 0..2 oldest row, 6..8 newest row.
    typedef logic [WIN_TAPS-1:0][PIX_W-1:0] t_win;

endpackage

### rtl/core/lef_ram.sv
// Generic single-write, single-read synchronous RAM with registered read.
// Read-first on a same-address collision. No dependencies.
module lef_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/core/lef_kernel.sv
// Laplacian kernel: 8 * centre minus the eight neighbours, clamped to 0..255.
// Depends on lef_pkg.
module lef_kernel (
    input  lef_pkg::t_win              i_win,
    output logic [lef_pkg::PIX_W-1:0]  o_lap
);
    import lef_pkg::*;

    logic [PIX_W+2:0]        nb_sum;
    logic signed [PIX_W+4:0] acc;

    always_comb begin
        nb_sum = '0;
        for (int k = 0; k < WIN_TAPS; k++) begin
            if (k != TAP_CENTRE) begin
                nb_sum = nb_sum + (PIX_W+3)'(i_win[k]);
            end
        end
        acc = $signed({2'b00, i_win[TAP_CENTRE], 3'b000}) - $signed({2'b00, nb_sum});
        if (acc < 0) begin
            o_lap = '0;
        end else if (acc > $signed((PIX_W+5)'(255))) begin
            o_lap = '1;
        end else begin
            o_lap = acc[PIX_W-1:0];
        end
    end

endmodule

### rtl/core/laplacian_edge_filter_3x3.sv
// Top level of the streaming 3x3 Laplacian edge filter.
// Depends on lef_pkg, lef_ram (line store) and lef_kernel.
//
//  channel   | handshake                  | payload
//  ----------+----------------------------+------------------------------
//  pixel in  | i_in_valid / o_in_ready    | i_in_data  (t_pix_in)
//  result    | o_out_valid / i_out_ready  | o_out_data (t_pix_out)
//  config    | i_cfg_valid / o_cfg_ready  | i_cfg_index, i_cfg_data
//
// One pixel per cycle sustained while the output is not stalled. A pixel's
// transaction loads the window stage and reads the line store; the result
// enters the output register when that stage moves on, so the line store read
// data, the window shift and the kernel all work within the window stage.
// Both line rows live in one 16-bit wide memory; each pixel reads its column
// and writes it back in the next stage, with a forward for back-to-back hits.
// Reset clears counters, window and valids; the line store is not cleared.
// A stalled output holds the window stage; the input stalls only when that
// stage is occupied and cannot move.
module laplacian_edge_filter_3x3 (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  lef_pkg::t_pix_in                i_in_data,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output lef_pkg::t_pix_out               o_out_data,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic                            i_cfg_index,
    input  logic [lef_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import lef_pkg::*;

    // Configuration
    logic [FW_W-1:0] r_frame_width;
    logic [FH_W-1:0] r_frame_height;
    logic [FW_W-1:0] eff_width;
    logic [FH_W-1:0] eff_height;

    // Position counters (input side)
    logic [COL_W-1:0] r_col, n_col, cur_col;
    logic [ROW_W-1:0] r_row, n_row, cur_row;
    logic [FW_W-1:0]  col_inc;
    logic [ROW_W:0]   row_inc;

    // Window stage
    logic             r_s1_valid;
    logic [PIX_W-1:0] r_s1_px;
    logic [ROW_W-1:0] r_s1_row;
    logic [COL_W-1:0] r_s1_col;
    logic             r_s1_emit;
    logic             r_s1_filt;
    logic             r_fwd_hit;
    logic [PIX_W-1:0] r_fwd_a;
    logic [PIX_W-1:0] r_fwd_b;
    logic [2*PIX_W-1:0] line_rdata;
    logic [PIX_W-1:0] above1, above2;
    t_win             r_win, n_win;
    logic [PIX_W-1:0] lap;

    // Output register
    logic     r_out_valid;
    t_pix_out r_out_data;

    logic in_xact, s1_go, out_en;

    assign o_cfg_ready = 1'b1;

    // Handshakes
    assign out_en     = !r_out_valid || i_out_ready;
    assign s1_go      = r_s1_valid && out_en;
    assign o_in_ready = !r_s1_valid || out_en;
    assign in_xact    = i_in_valid && o_in_ready;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= FW_W'(FW_RESET);
            r_frame_height <= FH_W'(FH_RESET);
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_FRAME_WIDTH:  r_frame_width  <= i_cfg_data[FW_W-1:0];
                CFG_FRAME_HEIGHT: r_frame_height <= i_cfg_data[FH_W-1:0];
                default: ;
            endcase
        end
    end

    // Clamp the frame size to at least MIN_DIM and the width to what the line store can hold
    always_comb begin
        if (r_frame_width < FW_W'(MIN_DIM)) begin
            eff_width = FW_W'(MIN_DIM);
        end else if (r_frame_width > FW_W'(MAX_WIDTH)) begin
            eff_width = FW_W'(MAX_WIDTH);
        end else begin
            eff_width = r_frame_width;
        end
        if (r_frame_height < FH_W'(MIN_DIM)) begin
            eff_height = FH_W'(MIN_DIM);
        end else begin
            eff_height = r_frame_height;
        end
    end

    // Position of the incoming pixel and the position after it
    always_comb begin
        cur_col = i_in_data.frame_start ? '0 : r_col;
        cur_row = i_in_data.frame_start ? '0 : r_row;
        col_inc = {1'b0, cur_col} + FW_W'(1);
        row_inc = {1'b0, cur_row} + (ROW_W+1)'(1);
        if (col_inc >= eff_width) begin
            n_col = '0;
            if (row_inc >= {1'b0, eff_height}) begin
                n_row = '0;
            end else begin
                n_row = row_inc[ROW_W-1:0];
            end
        end else begin
            n_col = col_inc[COL_W-1:0];
            n_row = cur_row;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (in_xact) begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    // Line store: low byte is the row above, high byte two rows above
    lef_ram #(
        .WIDTH (2*PIX_W),
        .DEPTH (MAX_WIDTH)
    ) u_line_ram (
        .i_clk   (i_clk),
        .i_we    (s1_go),
        .i_waddr (r_s1_col[LINE_ADDR_W-1:0]),
        .i_wdata ({above1, r_s1_px}),
        .i_re    (in_xact),
        .i_raddr (cur_col[LINE_ADDR_W-1:0]),
        .o_rdata (line_rdata)
    );

    // Forward the write-back of the leaving pixel when the read of the new
    // pixel hits the same column at the same edge
    assign above1 = r_fwd_hit ? r_fwd_a : line_rdata[PIX_W-1:0];
    assign above2 = r_fwd_hit ? r_fwd_b : line_rdata[2*PIX_W-1:PIX_W];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_s1_valid <= in_xact;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xact) begin
            r_s1_px   <= i_in_data.pixel_in;
            r_s1_row  <= cur_row;
            r_s1_col  <= cur_col;
            r_s1_emit <= (cur_row != '0) && (cur_col != '0);
            r_s1_filt <= (cur_row >= ROW_W'(2)) && (cur_col >= COL_W'(2));
            r_fwd_hit <= s1_go && (r_s1_col == cur_col);
            r_fwd_a   <= r_s1_px;
            r_fwd_b   <= above1;
        end
    end

    // Shift the window one column left and insert the new column
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            n_win[3*k]   = r_win[3*k+1];
            n_win[3*k+1] = r_win[3*k+2];
        end
        n_win[2] = above2;
        n_win[5] = above1;
        n_win[8] = r_s1_px;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win <= '0;
        end else if (s1_go) begin
            r_win <= n_win;
        end
    end

    lef_kernel u_kernel (
        .i_win (n_win),
        .o_lap (lap)
    );

    // Output register: drop transactions that produce no result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_en) begin
            r_out_valid <= s1_go && r_s1_emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_go) begin
            r_out_data.pixel_out <= r_s1_filt ? lap : n_win[TAP_CENTRE];
            r_out_data.out_row   <= r_s1_row - ROW_W'(1);
            r_out_data.out_col   <= r_s1_col - COL_W'(1);
            r_out_data.filtered  <= r_s1_filt;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule
